// ===== hdl/apeq_pkg.sv =====
// ----------------------------------------------------------------------------
// apeq_pkg
// Shared types, constants and the microprogram of the allpass peaking
// equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package apeq_pkg;

    // default widths of sample and lattice state
    localparam int SAMPLE_W_DEF = 24;
    localparam int STATE_W_DEF  = 48;

    // fixed field widths
    localparam int COEF_W    = 23;
    localparam int GAIN_W    = 24;
    localparam int ENV_W     = 16;
    localparam int LIM_W     = 47;
    localparam int CFG_W     = 47;
    localparam int CFG_IDX_W = 3;

    // effective gain, signed Q.20, and the magnitude of any multiplier coefficient
    localparam int G_W    = 27;
    localparam int KMAG_W = G_W - 1;

    localparam int UNITY_GAIN = 1048576;

    // fractional bits of the three product formats
    localparam int FRAC_COEF = 22;
    localparam int FRAC_GAIN = 20;
    localparam int FRAC_ENV  = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_GAIN   = 3'd2,
        REG_MODE   = 3'd3,
        REG_SLIMIT = 3'd4,
        REG_BLIMIT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] center_coef;
        logic signed [COEF_W-1:0] width_coef;
        logic [GAIN_W-1:0]        peak_gain;
        logic                     envelope_mode;
        logic [LIM_W-1:0]         state_limit;
        logic [LIM_W-1:0]         blowup_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{'0, '0, GAIN_W'(UNITY_GAIN), 1'b0, '1, '1};

    // micro-operations of the datapath
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LD_U2,   // load multiplier with (x - s2) * k2
        UOP_MLO,     // low partial product
        UOP_MHI,     // high partial product
        UOP_FIN,     // round, saturate, sign
        UOP_O2AP,    // o2 and allpass output
        UOP_LD_U1,   // load multiplier with (o2 - s1) * k1
        UOP_UPD,     // new states, x + ap, plain gain
        UOP_LD_G,    // clamp s2, load multiplier with (gain - 1) * env
        UOP_GADD,    // effective gain
        UOP_LD_Y,    // load multiplier with (x - ap) * g
        UOP_SUMY,    // sum of both branches
        UOP_OUT      // output word, state write-back
    } t_uop;

    typedef enum logic [1:0] {
        FSEL_22,
        FSEL_20,
        FSEL_15
    } t_fsel;

    typedef enum logic {
        COND_NONE,
        COND_PLAIN
    } t_cond;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_ZERO = 5'd0;
    localparam t_step STEP_LD_Y = 5'd15;

    typedef struct packed {
        t_uop  uop;
        t_fsel fsel;
        t_cond cond;
        t_step target;
        logic  last;
    } t_ctrl;

    localparam t_ctrl CTRL_NOP = '{UOP_NOP, FSEL_22, COND_NONE, STEP_ZERO, 1'b0};

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    function automatic logic [4:0] frac_bits(input t_fsel fsel);
        logic [4:0] n;
        case (fsel)
            FSEL_20: n = 5'(FRAC_GAIN);
            FSEL_15: n = 5'(FRAC_ENV);
            default: n = 5'(FRAC_COEF);
        endcase
        return n;
    endfunction

    // control store
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        case (step)
            5'd0:    w = '{UOP_LD_U2, FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd1:    w = '{UOP_MLO,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd2:    w = '{UOP_MHI,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd3:    w = '{UOP_FIN,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd4:    w = '{UOP_O2AP,  FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd5:    w = '{UOP_LD_U1, FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd6:    w = '{UOP_MLO,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd7:    w = '{UOP_MHI,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd8:    w = '{UOP_FIN,   FSEL_22, COND_NONE,  STEP_ZERO, 1'b0};
            5'd9:    w = '{UOP_UPD,   FSEL_22, COND_PLAIN, STEP_LD_Y, 1'b0};
            5'd10:   w = '{UOP_LD_G,  FSEL_15, COND_NONE,  STEP_ZERO, 1'b0};
            5'd11:   w = '{UOP_MLO,   FSEL_15, COND_NONE,  STEP_ZERO, 1'b0};
            5'd12:   w = '{UOP_MHI,   FSEL_15, COND_NONE,  STEP_ZERO, 1'b0};
            5'd13:   w = '{UOP_FIN,   FSEL_15, COND_NONE,  STEP_ZERO, 1'b0};
            5'd14:   w = '{UOP_GADD,  FSEL_15, COND_NONE,  STEP_ZERO, 1'b0};
            5'd15:   w = '{UOP_LD_Y,  FSEL_20, COND_NONE,  STEP_ZERO, 1'b0};
            5'd16:   w = '{UOP_MLO,   FSEL_20, COND_NONE,  STEP_ZERO, 1'b0};
            5'd17:   w = '{UOP_MHI,   FSEL_20, COND_NONE,  STEP_ZERO, 1'b0};
            5'd18:   w = '{UOP_FIN,   FSEL_20, COND_NONE,  STEP_ZERO, 1'b0};
            5'd19:   w = '{UOP_SUMY,  FSEL_20, COND_NONE,  STEP_ZERO, 1'b0};
            5'd20:   w = '{UOP_OUT,   FSEL_20, COND_NONE,  STEP_ZERO, 1'b1};
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/apeq_in_if.sv =====
// ----------------------------------------------------------------------------
// apeq_in_if
// Input channel: one sample and its envelope weight per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface apeq_in_if
    import apeq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [ENV_W-1:0]               envelope;

    modport source (output valid, output sample_in, output envelope, input ready);
    modport sink   (input valid, input sample_in, input envelope, output ready);
endinterface

`default_nettype wire

// ===== hdl/apeq_out_if.sv =====
// ----------------------------------------------------------------------------
// apeq_out_if
// Output channel: one equalized sample and the state-cleared flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface apeq_out_if
    import apeq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           state_cleared;

    modport source (output valid, output sample_out, output state_cleared, input ready);
    modport sink   (input valid, input sample_out, input state_cleared, output ready);
endinterface

`default_nettype wire

// ===== hdl/apeq_mulq.sv =====
// ----------------------------------------------------------------------------
// apeq_mulq
// Shared fractional multiplier: magnitude of a state-format operand times a
// coefficient, in two partial products split at operand bit 32, rounded half
// away from zero and saturated symmetrically to the state range.
// ----------------------------------------------------------------------------
`default_nettype none

module apeq_mulq
    import apeq_pkg::*;
#(
    parameter int STATE_WIDTH = STATE_W_DEF
) (
    input  wire                           i_clk,
    input  t_ctrl                         i_ctrl,
    input  wire logic signed [STATE_WIDTH-1:0] i_a,
    input  wire logic signed [G_W-1:0]    i_k,
    output logic signed [STATE_WIDTH-1:0] o_p
);
    localparam int HI_W  = (STATE_WIDTH > 32) ? STATE_WIDTH - 32 : 1;
    localparam int TOT_W = HI_W + 32 + KMAG_W + 1;
    localparam logic [STATE_WIDTH-1:0] MAG_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};

    logic [STATE_WIDTH-1:0]   r_ma;
    logic [KMAG_W-1:0]        r_mk;
    logic                     r_neg;
    logic [32+KMAG_W-1:0]     r_plo;
    logic [HI_W+KMAG_W-1:0]   r_phi;
    logic signed [STATE_WIDTH-1:0] r_p;

    logic [STATE_WIDTH-1:0]   a_mag;
    logic [G_W-1:0]           k_mag;
    logic [32+HI_W-1:0]       ma_ext;
    logic [4:0]               shamt;
    logic [TOT_W-1:0]         tot;
    logic [TOT_W-1:0]         shifted;
    logic [STATE_WIDTH-1:0]   m;

    always_comb begin
        a_mag   = i_a[STATE_WIDTH-1] ? STATE_WIDTH'(~i_a + 1'b1) : STATE_WIDTH'(i_a);
        k_mag   = i_k[G_W-1] ? G_W'(~i_k + 1'b1) : G_W'(i_k);
        ma_ext  = (32 + HI_W)'(r_ma);
        shamt   = frac_bits(i_ctrl.fsel);
        tot     = TOT_W'({r_phi, 32'b0}) + TOT_W'(r_plo)
                + (TOT_W'(1) << 5'(shamt - 5'd1));
        shifted = tot >> shamt;
        m       = (shifted > TOT_W'(MAG_MAX)) ? MAG_MAX : shifted[STATE_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.uop)
            UOP_LD_U2, UOP_LD_U1, UOP_LD_G, UOP_LD_Y: begin
                r_ma  <= a_mag;
                r_mk  <= k_mag[KMAG_W-1:0];
                r_neg <= i_a[STATE_WIDTH-1] ^ i_k[G_W-1];
            end
            UOP_MLO: r_plo <= ma_ext[31:0] * r_mk;
            UOP_MHI: r_phi <= ma_ext[32 +: HI_W] * r_mk;
            UOP_FIN: r_p   <= r_neg ? $signed(~m + 1'b1) : $signed(m);
            default: ;
        endcase
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/apeq_dpath.sv =====
// ----------------------------------------------------------------------------
// apeq_dpath
// Lattice datapath: state and scratch registers, saturating adders and the
// operand selection for the shared multiplier, driven by the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module apeq_dpath
    import apeq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    parameter int STATE_WIDTH  = STATE_W_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  t_ctrl                          i_ctrl,
    input  t_cfg                           i_cfg,
    input  wire                            i_start,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic [ENV_W-1:0]          i_env,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_state_cleared
);
    localparam int SW    = STATE_WIDTH;
    localparam int CMP_W = (SW > LIM_W) ? SW : LIM_W;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] Y_MAX = SW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] Y_MIN = ~Y_MAX;

    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? SMIN : SMAX;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_sub(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} - {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? SMIN : SMAX;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] a);
        return a[SW-1] ? SW'(~a + 1'b1) : SW'(a);
    endfunction

    logic signed [SW-1:0] r_x, r_s1, r_s2, r_o2, r_ap, r_t1, r_t2, r_sum, r_y;
    logic [ENV_W-1:0]     r_env;
    logic signed [G_W-1:0] r_g;
    logic signed [SAMPLE_WIDTH-1:0] r_sout;
    logic                 r_clr;

    logic signed [SW-1:0] x_in;
    logic signed [SW-1:0] mul_a, mul_p;
    logic signed [G_W-1:0] mul_k;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] gain_m1;
    logic [SW-1:0]        rnd;
    logic signed [SW-1:0] y_rnd, y_sat;
    logic                 blowup;

    assign x_in    = SW'(i_sample);
    assign gain_m1 = SW'({1'b0, i_cfg.peak_gain}) - SW'(UNITY_GAIN);

    // clamp bound: the smaller of the limit register and the state maximum
    assign lim = (CMP_W'(i_cfg.state_limit) > CMP_W'(SMAX)) ? SMAX
                                                           : SW'(i_cfg.state_limit);

    always_comb begin
        case (i_ctrl.uop)
            UOP_LD_U2: begin
                mul_a = sat_sub(r_x, r_s2);
                mul_k = G_W'(i_cfg.width_coef);
            end
            UOP_LD_U1: begin
                mul_a = sat_sub(r_o2, r_s1);
                mul_k = G_W'(i_cfg.center_coef);
            end
            UOP_LD_G: begin
                mul_a = gain_m1;
                mul_k = G_W'({1'b0, r_env});
            end
            UOP_LD_Y: begin
                mul_a = sat_sub(r_x, r_ap);
                mul_k = r_g;
            end
            default: begin
                mul_a = '0;
                mul_k = '0;
            end
        endcase
    end

    always_comb begin
        rnd   = (mag(r_y) + SW'(2)) >> 2;
        y_rnd = r_y[SW-1] ? $signed(~rnd + 1'b1) : $signed(rnd);
        if (y_rnd > Y_MAX) begin
            y_sat = Y_MAX;
        end else if (y_rnd < Y_MIN) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = y_rnd;
        end
        blowup = i_cfg.envelope_mode
               && ((CMP_W'(mag(r_t1)) > CMP_W'(i_cfg.blowup_limit))
               ||  (CMP_W'(mag(r_t2)) > CMP_W'(i_cfg.blowup_limit)));
    end

    apeq_mulq #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mulq (
        .i_clk  (i_clk),
        .i_ctrl (i_ctrl),
        .i_a    (mul_a),
        .i_k    (mul_k),
        .o_p    (mul_p)
    );

    // lattice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_ctrl.uop == UOP_OUT) begin
            r_s1 <= blowup ? '0 : r_t1;
            r_s2 <= blowup ? '0 : r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= x_in <<< 1;
            r_env <= i_env;
        end
        case (i_ctrl.uop)
            UOP_O2AP: begin
                r_o2 <= sat_add(r_x, mul_p);
                r_ap <= sat_add(r_s2, mul_p);
            end
            UOP_UPD: begin
                r_t2  <= sat_add(mul_p, r_s1);
                r_t1  <= sat_add(mul_p, r_o2);
                r_sum <= sat_add(r_x, r_ap);
                r_g   <= G_W'(i_cfg.peak_gain);
            end
            UOP_LD_G: begin
                if (r_t2 > lim) begin
                    r_t2 <= lim;
                end else if (r_t2 < -lim) begin
                    r_t2 <= -lim;
                end
            end
            UOP_GADD: r_g <= G_W'(mul_p) + G_W'(UNITY_GAIN);
            UOP_SUMY: r_y <= sat_add(r_sum, mul_p);
            UOP_OUT: begin
                r_sout <= y_sat[SAMPLE_WIDTH-1:0];
                r_clr  <= blowup;
            end
            default: ;
        endcase
    end

    assign o_sample_out    = r_sout;
    assign o_state_cleared = r_clr;

endmodule

`default_nettype wire

// ===== hdl/apeq_useq.sv =====
// ----------------------------------------------------------------------------
// apeq_useq
// Microcode sequencer: step counter over the control store, with the plain
// mode jump past the envelope gain and a hold on the output step.
// ----------------------------------------------------------------------------
`default_nettype none

module apeq_useq
    import apeq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_start,
    input  wire   i_hold,
    input  wire   i_plain,
    output t_ctrl o_ctrl,
    output logic  o_idle
);
    t_seq_state r_state, n_state;
    t_step      r_step, n_step;
    t_ctrl      rom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= STEP_ZERO;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        rom     = ucode(r_step);
        o_ctrl  = CTRL_NOP;
        o_idle  = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_step  = STEP_ZERO;
                end
            end
            SEQ_RUN: begin
                // hold the last step while the previous word is still unread
                if (!(rom.last && i_hold)) begin
                    o_ctrl = rom;
                    if (rom.last) begin
                        n_state = SEQ_IDLE;
                    end else if (rom.cond == COND_PLAIN && i_plain) begin
                        n_step = rom.target;
                    end else begin
                        n_step = t_step'(r_step + 1'b1);
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/allpass_peaking_equalizer.sv =====
// ----------------------------------------------------------------------------
// allpass_peaking_equalizer
// Peaking equalizer on a second-order allpass lattice, microcoded datapath.
// ----------------------------------------------------------------------------
// Channels: i_in carries one signed sample and an unsigned envelope weight per
// word, o_out one saturated sample and a flag set when the lattice states were
// zeroed by the blowup check. Both use valid/ready; a word moves when both
// are high. Coefficients, gain, mode and limits are written through the
// i_cfg_* port, one register per cycle; the user must write them only while
// no word is in flight, as the block itself does not enforce it.
// Each word runs through a short microprogram on one shared multiplier; each
// product takes four steps (operand load, two partial products split at
// operand bit 32, round and saturate). Plain mode takes 16 steps, envelope
// mode 21 (one more product for the effective gain). The result is registered
// on the output step; a new word is taken only once the sequencer is idle.
// The output register parts the two sides: a new word is taken while a result
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds on its final step. Reset clears the states, the handshake
// and the registers to unity gain, plain mode and full-scale limits.
// ----------------------------------------------------------------------------
`default_nettype none

module allpass_peaking_equalizer
    import apeq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    parameter int STATE_WIDTH  = STATE_W_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]      i_cfg_data,
    apeq_in_if.sink              i_in,
    apeq_out_if.source           o_out
);
    t_cfg  r_cfg;
    logic  r_out_valid;
    t_ctrl ctrl;
    logic  seq_idle;
    logic  in_acc;
    logic  out_hold;

    assign in_acc   = i_in.valid && seq_idle;
    assign out_hold = r_out_valid && !o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CENTER: r_cfg.center_coef   <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_WIDTH:  r_cfg.width_coef    <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_GAIN:   r_cfg.peak_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_MODE:   r_cfg.envelope_mode <= i_cfg_data[0];
                REG_SLIMIT: r_cfg.state_limit   <= i_cfg_data[LIM_W-1:0];
                REG_BLIMIT: r_cfg.blowup_limit  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    apeq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_hold  (out_hold),
        .i_plain (!r_cfg.envelope_mode),
        .o_ctrl  (ctrl),
        .o_idle  (seq_idle)
    );

    apeq_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cfg           (r_cfg),
        .i_start         (in_acc),
        .i_sample        (i_in.sample_in),
        .i_env           (i_in.envelope),
        .o_sample_out    (o_out.sample_out),
        .o_state_cleared (o_out.state_cleared)
    );

    // output word valid: set on the final step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.uop == UOP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready  = seq_idle;
    assign o_out.valid = r_out_valid;

endmodule

`default_nettype wire
